FILE: rtl/core/fsd_pkg.sv
// ----------------------------------------------------------------------------
// fsd_pkg: shared definitions for the flux stream decoder
// Result kinds, item and result structures, and default sizes.
// ----------------------------------------------------------------------------
package fsd_pkg;

  // Default width of the sample counters.
  localparam int unsigned CountWidth = 32;

  // Width of the samples field of a result item.
  localparam int unsigned SamplesWidth = 32;

  typedef enum logic [1:0] {
    KindFlux  = 2'd0,
    KindIndex = 2'd1,
    KindEnd   = 2'd2,
    KindBad   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic                           valid;
    kind_e                          kind;
    logic signed [SamplesWidth-1:0] samples;
  } result_t;

endpackage

FILE: rtl/core/fsd_in_if.sv
// ----------------------------------------------------------------------------
// fsd_in_if: input byte channel
// Carries one stream byte and its end-of-stream flag per item.
// ----------------------------------------------------------------------------
interface fsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

FILE: rtl/core/fsd_out_if.sv
// ----------------------------------------------------------------------------
// fsd_out_if: decoded event channel
// Carries one event kind and its sample position per item.
// ----------------------------------------------------------------------------
interface fsd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] samples;

  modport source (output valid, output kind, output samples, input ready);
  modport sink (input valid, input kind, input samples, output ready);
endinterface

FILE: rtl/core/fsd_core.sv
// ----------------------------------------------------------------------------
// fsd_core: stream decoding state and per-byte logic
// Holds the token state and sample counters and computes the result of a byte.
// ----------------------------------------------------------------------------
module fsd_core #(
  parameter int unsigned CountWidth = fsd_pkg::CountWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  fsd_pkg::item_t  item_i,
  output fsd_pkg::result_t res_o
);
  import fsd_pkg::*;

  typedef enum logic [1:0] {
    PhToken  = 2'd0,
    PhLong   = 2'd1,
    PhOpcode = 2'd2,
    PhField  = 2'd3
  } phase_e;

  localparam logic [7:0] OpIndex = 8'd1;
  localparam logic [7:0] OpSpace = 8'd2;
  localparam logic [7:0] LongStart = 8'd250;
  localparam logic [7:0] Escape = 8'd255;

  phase_e                phase_q, phase_d;
  logic [CountWidth-1:0] pending_q, pending_d;
  logic [CountWidth-1:0] since_q, since_d;
  logic [2:0]            long_high_q, long_high_d;
  logic [27:0]           field_q, field_d;
  logic [1:0]            field_cnt_q, field_cnt_d;
  logic                  field_idx_q, field_idx_d;
  logic                  field_done_q, field_done_d;
  logic                  failed_q, failed_d;

  logic [7:0]            b;
  logic [11:0]           long_amount;
  logic [27:0]           field_new;
  logic [CountWidth-1:0] ahead;
  logic [CountWidth-1:0] flux_pos;

  assign b = item_i.data_byte;

  // Long flux length: 249 + high * 255 + second byte.
  assign long_amount = 12'd249 + {1'b0, long_high_q, 8'd0} - {9'd0, long_high_q}
                     + {4'd0, b};

  always_comb begin
    field_new = field_q;
    case (field_cnt_q)
      2'd0: field_new[6:0]   = field_q[6:0]   | b[7:1];
      2'd1: field_new[13:7]  = field_q[13:7]  | b[7:1];
      2'd2: field_new[20:14] = field_q[20:14] | b[7:1];
      default: field_new[27:21] = field_q[27:21] | b[7:1];
    endcase
  end

  assign ahead = pending_q + CountWidth'(field_new);

  always_comb begin
    flux_pos = since_q + pending_q;
    if (phase_q == PhLong) begin
      flux_pos = flux_pos + CountWidth'(long_amount);
    end else begin
      flux_pos = flux_pos + CountWidth'(b);
    end
  end

  always_comb begin
    phase_d      = phase_q;
    pending_d    = pending_q;
    since_d      = since_q;
    long_high_d  = long_high_q;
    field_d      = field_q;
    field_cnt_d  = field_cnt_q;
    field_idx_d  = field_idx_q;
    field_done_d = field_done_q;
    failed_d     = failed_q;
    res_o        = '{valid: 1'b0, kind: KindFlux, samples: '0};

    if (step_i) begin
      if (item_i.is_last) begin
        if (!failed_q) begin
          res_o.valid = 1'b1;
          res_o.kind  = ((b != 8'd0) || (phase_q != PhToken) || field_done_q) ?
                        KindBad : KindEnd;
        end
        phase_d      = PhToken;
        pending_d    = '0;
        since_d      = '0;
        long_high_d  = '0;
        field_d      = '0;
        field_cnt_d  = '0;
        field_idx_d  = 1'b0;
        field_done_d = 1'b0;
        failed_d     = 1'b0;
      end else if (!failed_q) begin
        unique case (phase_q)
          PhLong: begin
            phase_d       = PhToken;
            pending_d     = '0;
            since_d       = flux_pos;
            res_o.valid   = 1'b1;
            res_o.samples = SamplesWidth'(flux_pos);
          end
          PhOpcode: begin
            if ((b == OpIndex) || (b == OpSpace)) begin
              field_idx_d = (b == OpIndex);
              field_d     = '0;
              field_cnt_d = '0;
              phase_d     = PhField;
            end else begin
              failed_d    = 1'b1;
              phase_d     = PhToken;
              res_o.valid = 1'b1;
              res_o.kind  = KindBad;
            end
          end
          PhField: begin
            field_d = field_new;
            if (field_cnt_q != 2'd3) begin
              field_cnt_d = field_cnt_q + 2'd1;
            end else begin
              field_cnt_d  = '0;
              phase_d      = PhToken;
              field_done_d = 1'b1;
              if (field_idx_q) begin
                since_d       = -ahead;
                res_o.valid   = 1'b1;
                res_o.kind    = KindIndex;
                res_o.samples = SamplesWidth'(since_q + ahead);
              end else begin
                pending_d = ahead;
              end
            end
          end
          default: begin
            phase_d      = PhToken;
            field_done_d = 1'b0;
            if (b < LongStart) begin
              pending_d     = '0;
              since_d       = flux_pos;
              res_o.valid   = 1'b1;
              res_o.samples = SamplesWidth'(flux_pos);
            end else if (b != Escape) begin
              long_high_d = 3'(b - LongStart);
              phase_d     = PhLong;
            end else begin
              phase_d = PhOpcode;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhToken;
      pending_q    <= '0;
      since_q      <= '0;
      long_high_q  <= '0;
      field_q      <= '0;
      field_cnt_q  <= '0;
      field_idx_q  <= 1'b0;
      field_done_q <= 1'b0;
      failed_q     <= 1'b0;
    end else begin
      phase_q      <= phase_d;
      pending_q    <= pending_d;
      since_q      <= since_d;
      long_high_q  <= long_high_d;
      field_q      <= field_d;
      field_cnt_q  <= field_cnt_d;
      field_idx_q  <= field_idx_d;
      field_done_q <= field_done_d;
      failed_q     <= failed_d;
    end
  end

  // The final byte always leaves a fresh stream behind it.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.is_last |=> (phase_q == PhToken) && !failed_q && (since_q == '0))
    else $error("stream state not cleared after final byte");

  // An unknown opcode latches the error flag.
  a_bad_opcode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !item_i.is_last && !failed_q && (phase_q == PhOpcode) &&
    (item_i.data_byte != OpIndex) && (item_i.data_byte != OpSpace) |=> failed_q)
    else $error("unknown opcode did not set the error flag");

  // While failed, only the final byte may touch state, and it reports nothing.
  a_failed_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |-> !res_o.valid)
    else $error("result produced after a stream error");

endmodule

FILE: rtl/core/flux_stream_decoder.sv
// ----------------------------------------------------------------------------
// flux_stream_decoder: floppy flux-sample stream decoder
// Turns a byte stream into flux, index and end-of-stream events.
// ----------------------------------------------------------------------------
//
//   Port    Dir  Moves per item
//   ------  ---  -------------------------------------------------------------
//   in_i    in   data_byte (8 b) and is_last (1 b): one raw stream byte
//   out_o   out  kind (2 b) and samples (32 b signed): one decoded event
//
// Each byte is captured in an input register and decoded from there, one
// byte per cycle sustained while out_o does not stall; its event is then
// written to the event register, which offers it on out_o.
// The event register lets a new byte enter while an event still waits.
// The decode between the input and event registers is one short pass of
// adds through the decoder state.
// Reset clears all stream state; the decoder then expects a new token.
// A stall on out_o holds the input register, and in_i.ready drops once
// that register is full.
//
module flux_stream_decoder #(
  parameter int unsigned COUNT_WIDTH = fsd_pkg::CountWidth
) (
  input logic      clk_i,
  input logic      rst_ni,
  fsd_in_if.sink   in_i,
  fsd_out_if.source out_o
);
  import fsd_pkg::*;

  // Input register holding the byte under decode.
  logic    in_valid_q;
  item_t   in_item_q;

  // Result register feeding the output channel.
  logic                           out_valid_q;
  kind_e                          out_kind_q;
  logic signed [SamplesWidth-1:0] out_samples_q;

  logic    advance;
  result_t res;

  // The held byte is decoded once there is room for whatever event it makes.
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_item_q <= '{data_byte: in_i.data_byte, is_last: in_i.is_last};
    end
  end

  fsd_core #(
    .CountWidth(COUNT_WIDTH)
  ) u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(advance),
    .item_i(in_item_q),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res.valid) begin
      out_kind_q    <= res.kind;
      out_samples_q <= res.samples;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.kind    = out_kind_q;
  assign out_o.samples = out_samples_q;

  // Ready only drops while a byte is held back by a stalled event.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q && out_valid_q && !out_o.ready)
    else $error("input stalled without a pending event");

  // Stream end and error events carry no sample count.
  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && ((out_kind_q == KindEnd) || (out_kind_q == KindBad))
    |-> out_samples_q == '0)
    else $error("end or error event with nonzero samples");

  // A held event is not overwritten while the consumer stalls.
  a_event_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_kind_q) &&
    $stable(out_samples_q))
    else $error("stalled event changed");

endmodule

FILE: tb/sv/tb_flux_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flux_stream_decoder: self-checking bench for the flux stream decoder
// Feeds byte streams through the input channel, predicts every decoded event
// with a cycle-free model of the decoder, and checks each event on the output
// channel in order. Both channels idle and stall in random bursts.
// ----------------------------------------------------------------------------
module tb_flux_stream_decoder;
  import fsd_pkg::*;

  typedef logic [CountWidth-1:0] count_t;

  // Decoder phases, as the predictor tracks them.
  typedef enum logic [1:0] {
    PhToken  = 2'd0,
    PhLong   = 2'd1,
    PhOpcode = 2'd2,
    PhField  = 2'd3
  } phase_e;

  // One decoded event as it should appear on the output channel.
  typedef struct {
    kind_e              kind;
    logic signed [31:0] samples;
  } decoded_t;

  // Stream byte codes.
  localparam logic [7:0] LongBase = 8'd250;
  localparam logic [7:0] LongTop  = 8'd254;
  localparam logic [7:0] Escape   = 8'd255;
  localparam logic [7:0] OpIndex  = 8'd1;
  localparam logic [7:0] OpSpace  = 8'd2;
  localparam logic [7:0] EndByte  = 8'd0;

  localparam int unsigned RandomBytes = 440;
  localparam int unsigned FullRateBytes = 60;
  localparam int unsigned SettleCycles = 20;

  logic clk_i;
  logic rst_ni;

  fsd_in_if  in_if ();
  fsd_out_if out_if ();

  flux_stream_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted decoder state. It is advanced once per accepted item, in the
  // order the items are accepted, so it always mirrors what the decoder has
  // seen so far.
  phase_e      phase;
  count_t      pending;
  count_t      since_index;
  logic [2:0]  long_high;
  logic [27:0] field_value;
  logic [1:0]  field_count;
  logic        field_is_index;
  logic        field_just_done;
  logic        failed;

  // Events the decoder still owes us, oldest first.
  decoded_t decoded_q[$];

  int  mismatches = 0;
  int  bytes_decoded = 0;
  bit  idle_en = 1'b1;
  int  quiet_left = 0;
  int  stall_left = 0;
  int  flow_left = 0;
  decoded_t head;

  // --------------------------------------------------------------------------
  // Clock and limit
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Even with every item waiting out the longest gap and stall, the slowest
  // correct run ends well inside the 5 ms limit, which leaves a wide margin.
  initial begin
    #5_000_000;
    $display("%0t: timeout with %0d events outstanding", $time, decoded_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic void clear_stream();
    phase           = PhToken;
    pending         = '0;
    since_index     = '0;
    long_high       = '0;
    field_value     = '0;
    field_count     = '0;
    field_is_index  = 1'b0;
    field_just_done = 1'b0;
    failed          = 1'b0;
  endfunction

  function automatic void owe_event(kind_e kind, count_t samples);
    decoded_q.push_back(decoded_t'{kind: kind, samples: samples[31:0]});
  endfunction

  // A flux folds any pending space into the count and reports the position
  // since the last index.
  function automatic void owe_flux(count_t amount);
    pending     = pending + amount;
    since_index = since_index + pending;
    pending     = '0;
    owe_event(KindFlux, since_index);
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    count_t ahead;
    logic   bad;
    // The terminator closes the stream. A stream that already reported an
    // unknown opcode stays quiet here, so each stream reports at most one error.
    if (last) begin
      if (!failed) begin
        bad = (b != EndByte) || (phase != PhToken) || field_just_done;
        owe_event(bad ? KindBad : KindEnd, '0);
      end
      clear_stream();
      return;
    end
    if (failed) return;
    case (phase)
      PhLong: begin
        phase = PhToken;
        owe_flux(count_t'(LongBase) + count_t'(long_high) * count_t'(255) +
                 count_t'(b) - count_t'(1));
      end
      PhOpcode: begin
        if (b == OpIndex || b == OpSpace) begin
          field_is_index = (b == OpIndex);
          field_value    = '0;
          field_count    = '0;
          phase          = PhField;
        end else begin
          failed = 1'b1;
          phase  = PhToken;
          owe_event(KindBad, '0);
        end
      end
      PhField: begin
        // Seven bits per byte, least significant group first.
        field_value = field_value | (28'(b[7:1]) << (7 * field_count));
        if (field_count != 2'd3) begin
          field_count = field_count + 2'd1;
        end else begin
          field_count     = '0;
          phase           = PhToken;
          field_just_done = 1'b1;
          if (field_is_index) begin
            // The index reports its own position, then the count restarts
            // from it; pending space is left as it is.
            ahead = pending + count_t'(field_value);
            owe_event(KindIndex, since_index + ahead);
            since_index = count_t'(0) - ahead;
          end else begin
            pending = pending + count_t'(field_value);
          end
        end
      end
      default: begin
        phase           = PhToken;
        field_just_done = 1'b0;
        if (b < LongBase) begin
          owe_flux(count_t'(b));
        end else if (b < Escape) begin
          long_high = 3'(b - LongBase);
          phase     = PhLong;
        end else begin
          phase = PhOpcode;
        end
      end
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stalls and the in-order check
  // --------------------------------------------------------------------------
  // Ready drops in random bursts between random runs of ready cycles, so stalls
  // land on every phase of the decoder's work; with idling off it stays high.
  always @(posedge clk_i) begin
    if (!idle_en) begin
      stall_left = 0;
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (flow_left > 0) begin
      flow_left--;
      out_if.ready <= 1'b1;
    end else if ($urandom_range(0, 2) == 0) begin
      stall_left = $urandom_range(1, 12) - 1;
      out_if.ready <= 1'b0;
    end else begin
      flow_left = $urandom_range(1, 40);
      out_if.ready <= 1'b1;
    end
  end

  // Every accepted event must match the oldest owed event, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected event, expected none, actual kind %0d samples %0d",
                 $time, out_if.kind, out_if.samples);
        mismatches++;
      end else begin
        head = decoded_q.pop_front();
        if (out_if.kind !== head.kind) begin
          $display("%0t: kind mismatch, expected %0d, actual %0d",
                   $time, head.kind, out_if.kind);
          mismatches++;
        end
        if (out_if.samples !== head.samples) begin
          $display("%0t: samples mismatch, expected %0d, actual %0d",
                   $time, head.samples, out_if.samples);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Sends one item and returns at the edge that accepts it. Valid is left
  // high so that back-to-back items need only one assignment per edge; a
  // gap lowers it first.
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_en && quiet_left == 0 && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end else if (quiet_left > 0) begin
      quiet_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      quiet_left = $urandom_range(10, 40);
    end
    in_if.valid     <= 1'b1;
    in_if.data_byte <= b;
    in_if.is_last   <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (!failed) bytes_decoded++;
    decode_byte(b, last);
  endtask

  // Holds the sender off until every owed event has come out.
  task automatic drain_events();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (decoded_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_field(input logic [27:0] value);
    for (int i = 0; i < 4; i++) send_byte({value[7*i +: 7], 1'($urandom_range(0, 1))}, 1'b0);
  endtask

  // Sends one random token. Field values are mostly random, now and then all
  // ones so that the 32-bit counts wrap within a run.
  task automatic send_token(input bit allow_faults);
    int          pick;
    logic [27:0] value;
    pick  = $urandom_range(0, 99);
    value = ($urandom_range(0, 7) == 0) ? 28'hfff_ffff : 28'($urandom());
    if (pick < 55) begin
      send_byte(8'($urandom_range(0, LongBase - 1)), 1'b0);
    end else if (pick < 72) begin
      send_byte(8'($urandom_range(LongBase, LongTop)), 1'b0);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 84) begin
      send_byte(Escape, 1'b0);
      send_byte(OpIndex, 1'b0);
      send_field(value);
    end else if (pick < 96 || !allow_faults) begin
      send_byte(Escape, 1'b0);
      send_byte(OpSpace, 1'b0);
      send_field(value);
    end else begin
      // Unknown opcode; the bytes after it must be ignored.
      send_byte(Escape, 1'b0);
      send_byte(($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(3, 255)), 1'b0);
      repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  // Sends one whole stream: most end with a clean terminator, some with a
  // nonzero last byte, some cut off inside a token.
  task automatic send_stream(input bit allow_faults);
    int ending;
    repeat ($urandom_range(0, 20)) send_token(allow_faults);
    ending = allow_faults ? $urandom_range(0, 9) : 9;
    if (ending == 0) begin
      send_byte(8'($urandom_range(1, 255)), 1'b1);
    end else if (ending == 1) begin
      case ($urandom_range(0, 2))
        0: send_byte(8'($urandom_range(LongBase, LongTop)), 1'b0);
        1: send_byte(Escape, 1'b0);
        default: begin
          send_byte(Escape, 1'b0);
          send_byte($urandom_range(0, 1) ? OpIndex : OpSpace, 1'b0);
          repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      endcase
      send_byte(EndByte, 1'b1);
    end else begin
      send_byte(EndByte, 1'b1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Short fluxes at both ends of their range, including a zero-length one,
  // and long fluxes with the smallest and largest lead bytes.
  task automatic test_flux_lengths();
    send_byte(8'd0, 1'b0);
    send_byte(8'd249, 1'b0);
    send_byte(LongBase, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(LongTop, 1'b0);
    send_byte(8'd255, 1'b0);
    send_byte(EndByte, 1'b1);
  endtask

  // A space followed by an index. The index field ends right before the
  // terminator, so the index is reported and the stream is still invalid.
  task automatic test_index_and_space();
    send_byte(Escape, 1'b0);
    send_byte(OpSpace, 1'b0);
    send_byte(8'hfe, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(Escape, 1'b0);
    send_byte(OpIndex, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(EndByte, 1'b1);
  endtask

  // A nonzero terminator, streams cut off inside a long flux and after an
  // escape, and an unknown opcode whose stream must report only once.
  task automatic test_stream_faults();
    send_byte(8'h81, 1'b1);
    send_byte(8'd251, 1'b0);
    send_byte(EndByte, 1'b1);
    send_byte(Escape, 1'b0);
    send_byte(EndByte, 1'b1);
    send_byte(Escape, 1'b0);
    send_byte(8'd0, 1'b0);
    send_byte(8'd3, 1'b0);
    send_byte(EndByte, 1'b1);
  endtask

  // Mostly well-formed streams with random content, with faults mixed in.
  // Halfway through, the sender waits for the output to run dry.
  task automatic test_random_streams();
    int goal;
    goal = bytes_decoded + RandomBytes;
    while (bytes_decoded < goal) begin
      send_stream(1'b1);
      if (bytes_decoded >= goal - RandomBytes / 2 && bytes_decoded < goal - RandomBytes / 2 + 30)
        drain_events();
    end
  endtask

  // The closing stretch runs with no idling on either side, at full rate.
  task automatic test_full_rate();
    int goal;
    idle_en = 1'b0;
    goal = bytes_decoded + FullRateBytes;
    while (bytes_decoded < goal) send_stream(1'b1);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.is_last   = 1'b0;
    clear_stream();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_flux_lengths();
    test_index_and_space();
    test_stream_faults();
    drain_events();
    test_random_streams();
    test_full_rate();

    // Let the last events out, then keep the clock running so the decoder can
    // show anything it should not produce.
    drain_events();
    repeat (SettleCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: flux_stream_decoder.f
rtl/core/fsd_pkg.sv
rtl/core/fsd_in_if.sv
rtl/core/fsd_out_if.sv
rtl/core/fsd_core.sv
rtl/core/flux_stream_decoder.sv
tb/sv/tb_flux_stream_decoder.sv
